FILE: hdl/bpc_pkg.sv
// Shared types, codes and constants for the battery poll conditioner.
`timescale 1ns / 1ps

package bpc_pkg;

  // Field widths
  localparam int PctW  = 7;
  localparam int MvW   = 16;
  localparam int CurW  = 16;
  localparam int EvtW  = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Saturation limit for the charge percent
  localparam logic [PctW-1:0] PctMax = 7'd100;

  // Register reset values
  localparam logic [PctW-1:0] SnapThresholdRst = 7'd5;
  localparam logic [MvW-1:0]  LowSetMvRst      = 16'd3400;
  localparam logic [MvW-1:0]  LowClearMvRst    = 16'd3500;

  // Item kind carried in the slave tuser
  typedef enum logic {
    ACT_POLL        = 1'b0,
    ACT_DISPLAY_OFF = 1'b1
  } action_t;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SNAP_THRESHOLD = 2'd0,
    CFG_LOW_SET_MV     = 2'd1,
    CFG_LOW_CLEAR_MV   = 2'd2
  } cfg_index_t;

  typedef enum logic [EvtW-1:0] {
    PWR_NONE       = 2'd0,
    PWR_CONNECT    = 2'd1,
    PWR_DISCONNECT = 2'd2
  } power_event_t;

  typedef enum logic [EvtW-1:0] {
    LOW_NONE    = 2'd0,
    LOW_RAISED  = 2'd1,
    LOW_CLEARED = 2'd2
  } low_event_t;

  typedef struct packed {
    logic [PctW-1:0] snap_threshold;
    logic [MvW-1:0]  low_set_mv;
    logic [MvW-1:0]  low_clear_mv;
  } cfg_t;

  typedef struct packed {
    action_t                action;
    logic [PctW-1:0]        raw_percent;
    logic [MvW-1:0]         voltage_mv;
    logic signed [CurW-1:0] avg_current_ma;
    logic                   cable_present;
  } in_item_t;

  typedef struct packed {
    logic [PctW-1:0] percent;
    logic            charging;
    logic            powered;
    logic            low_flag;
    power_event_t    power_event;
    low_event_t      low_event;
  } result_t;

endpackage

FILE: hdl/bpc_cfg.sv
// Configuration register file for the battery poll conditioner.
`timescale 1ns / 1ps

module bpc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bpc_pkg::CfgDataW-1:0]  cfg_data,
  output bpc_pkg::cfg_t                 cfg
);

  bpc_pkg::cfg_index_t index_code;

  assign index_code = bpc_pkg::cfg_index_t'(cfg_index);

  // Load the addressed register; drop writes to unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.snap_threshold <= bpc_pkg::SnapThresholdRst;
      cfg.low_set_mv     <= bpc_pkg::LowSetMvRst;
      cfg.low_clear_mv   <= bpc_pkg::LowClearMvRst;
    end else if (cfg_wr_en) begin
      unique case (index_code)
        bpc_pkg::CFG_SNAP_THRESHOLD: cfg.snap_threshold <= cfg_data[bpc_pkg::PctW-1:0];
        bpc_pkg::CFG_LOW_SET_MV:     cfg.low_set_mv     <= cfg_data[bpc_pkg::MvW-1:0];
        bpc_pkg::CFG_LOW_CLEAR_MV:   cfg.low_clear_mv   <= cfg_data[bpc_pkg::MvW-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/bpc_core.sv
// Filter, power edge and low-voltage hysteresis logic with its state registers.
`timescale 1ns / 1ps

module bpc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  bpc_pkg::in_item_t   item,
  input  bpc_pkg::cfg_t       cfg,
  output bpc_pkg::result_t    res
);

  logic [bpc_pkg::PctW-1:0] filtered_percent, filtered_percent_next;
  logic filter_seeded, filter_seeded_next;
  logic first_poll_pending, first_poll_pending_next;
  logic previous_power, previous_power_next;
  logic low_warning, low_warning_next;
  logic last_charging, last_charging_next;

  logic [bpc_pkg::PctW-1:0] raw_sat;
  logic [bpc_pkg::PctW-1:0] diff;
  logic [bpc_pkg::PctW+1:0] blend_sum;
  logic                     chrg;
  logic                     onp;
  bpc_pkg::power_event_t    power_event;
  bpc_pkg::low_event_t      low_event;

  // Saturate the raw reading and form the filter terms
  always_comb begin
    raw_sat   = (item.raw_percent > bpc_pkg::PctMax) ? bpc_pkg::PctMax : item.raw_percent;
    diff      = (raw_sat > filtered_percent) ? (raw_sat - filtered_percent)
                                             : (filtered_percent - raw_sat);
    blend_sum = {2'b00, filtered_percent} + {1'b0, filtered_percent, 1'b0}
              + {2'b00, raw_sat};
    chrg      = (item.avg_current_ma != '0) && !item.avg_current_ma[bpc_pkg::CurW-1];
    onp       = chrg || item.cable_present;
  end

  // Next state and events for this transaction
  always_comb begin
    filtered_percent_next   = filtered_percent;
    filter_seeded_next      = filter_seeded;
    first_poll_pending_next = first_poll_pending;
    previous_power_next     = previous_power;
    low_warning_next        = low_warning;
    last_charging_next      = last_charging;
    power_event             = bpc_pkg::PWR_NONE;
    low_event               = bpc_pkg::LOW_NONE;

    if (item.action == bpc_pkg::ACT_DISPLAY_OFF) begin
      low_warning_next = 1'b0;
    end else begin
      // Seed, snap or blend the filter
      if (!filter_seeded) begin
        filter_seeded_next    = 1'b1;
        filtered_percent_next = raw_sat;
      end else if (diff > cfg.snap_threshold) begin
        filtered_percent_next = raw_sat;
      end else begin
        filtered_percent_next = blend_sum[bpc_pkg::PctW+1:2];
      end

      last_charging_next = chrg;

      // Power edges, suppressed on the first poll
      if (first_poll_pending) begin
        first_poll_pending_next = 1'b0;
        previous_power_next     = onp;
      end else if (onp) begin
        if (!previous_power) begin
          power_event = bpc_pkg::PWR_CONNECT;
        end
        previous_power_next = 1'b1;
      end else if (previous_power) begin
        previous_power_next = 1'b0;
        power_event         = bpc_pkg::PWR_DISCONNECT;
      end

      // Low-voltage hysteresis: raise test first while clear
      if (!low_warning && (item.voltage_mv < cfg.low_set_mv)) begin
        low_warning_next = 1'b1;
        low_event        = bpc_pkg::LOW_RAISED;
      end else if (low_warning && (item.voltage_mv >= cfg.low_clear_mv)) begin
        low_warning_next = 1'b0;
        low_event        = bpc_pkg::LOW_CLEARED;
      end
    end
  end

  // Result reflects state after this transaction
  always_comb begin
    res.percent     = filtered_percent_next;
    res.charging    = last_charging_next;
    res.powered     = previous_power_next;
    res.low_flag    = low_warning_next;
    res.power_event = power_event;
    res.low_event   = low_event;
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_percent   <= '0;
      filter_seeded      <= 1'b0;
      first_poll_pending <= 1'b1;
      previous_power     <= 1'b0;
      low_warning        <= 1'b0;
      last_charging      <= 1'b0;
    end else if (step) begin
      filtered_percent   <= filtered_percent_next;
      filter_seeded      <= filter_seeded_next;
      first_poll_pending <= first_poll_pending_next;
      previous_power     <= previous_power_next;
      low_warning        <= low_warning_next;
      last_charging      <= last_charging_next;
    end
  end

endmodule

FILE: hdl/battery_poll_conditioner_top.sv
// Top level of the battery poll conditioner: input register, core and result register.
//
//   Channel  Direction  Handshake              Payload
//   s_*      in         s_tvalid / s_tready    tdata: raw_percent, voltage_mv,
//                                              avg_current_ma, cable_present; tuser: action
//   m_*      out        m_tvalid / m_tready    tdata: percent, charging, powered, low_flag,
//                                              power_event, low_event
//   cfg_*    in         cfg_wr_en              cfg_index, cfg_data (no read-back)
//
// One item per cycle while m_tready holds high; items pass input, then result register.
// The input register feeds the core, whose state and result commit together when the item
// moves into the result register. rst is synchronous and clears both valid flags, the
// filter state and the registers to their defaults. A stalled master side holds the result;
// the input register still takes one more item while the result waits.
`timescale 1ns / 1ps

module battery_poll_conditioner_top (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [39:0]                   s_tdata,  // [6:0] raw_percent, [22:7] voltage_mv,
                                                  // [38:23] avg_current_ma, [39] cable_present
  input  logic                          s_tuser,  // [0] action
  // master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,  // [6:0] percent, [7] charging, [8] powered,
                                                  // [9] low_flag, [11:10] power_event,
                                                  // [13:12] low_event, [15:14] zero
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bpc_pkg::CfgDataW-1:0]  cfg_data
);

  bpc_pkg::cfg_t     cfg;
  bpc_pkg::in_item_t in_item;
  bpc_pkg::result_t  core_res;
  bpc_pkg::result_t  out_res;
  logic              in_valid;
  logic              out_free;
  logic              step;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .cfg  (cfg),
    .res  (core_res)
  );

  // Pipeline flow control
  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.action         <= bpc_pkg::action_t'(s_tuser);
      in_item.raw_percent    <= s_tdata[6:0];
      in_item.voltage_mv     <= s_tdata[22:7];
      in_item.avg_current_ma <= s_tdata[38:23];
      in_item.cable_present  <= s_tdata[39];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= core_res;
    end
  end

  assign m_tdata = {2'b00, out_res.low_event, out_res.power_event, out_res.low_flag,
                    out_res.powered, out_res.charging, out_res.percent};

endmodule
